[rtl/websocket_frame_deframer_unmask_defines.svh]
// Assertion macros for the frame deframer/unmask block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_DEFINES_SVH

// same-cycle implication
`define WSDU_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSDU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/wsdu_pkg.sv]
// Shared types and constants for the frame deframer/unmask block.
// No dependencies.
`timescale 1ns / 1ps

package wsdu_pkg;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      PH_HDR1 = 5'b00001,
      PH_HDR2 = 5'b00010,
      PH_EXT  = 5'b00100,
      PH_KEY  = 5'b01000,
      PH_DATA = 5'b10000
   } phase_type;

   localparam logic [6:0] LEN7_EXT16  = 7'd126;
   localparam logic [6:0] LEN7_EXT64  = 7'd127;
   localparam logic [2:0] EXT16_COUNT = 3'd1;
   localparam logic [2:0] EXT64_COUNT = 3'd7;
   localparam logic [2:0] KEY_LAST    = 3'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic        last;
      logic [3:0]  frame_opcode;
      logic        frame_fin;
      logic [63:0] payload_length;
   } rsp_payload_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_stage_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } parse_result_type;

endpackage

[rtl/wsdu_ifs.sv]
// Valid/ready channel interfaces for the request and response streams.
// Depends on wsdu_pkg.
`timescale 1ns / 1ps

interface wsdu_req_if;
   import wsdu_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wsdu_rsp_if;
   import wsdu_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/wsdu_in_stage.sv]
// Input register: holds one received byte until the parser consumes it.
// Depends on wsdu_pkg and wsdu_req_if.
`timescale 1ns / 1ps

module wsdu_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   wsdu_req_if.sink              req_chan,
   input  logic                  advance,
   output wsdu_pkg::in_stage_type stage_out
);
   import wsdu_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       load;

   assign load           = !valid_ff || advance;
   assign req_chan.ready = load;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = req_chan.valid;
         if (req_chan.valid) begin
            byte_in = req_chan.payload.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage_out.valid   = valid_ff;
   assign stage_out.rx_byte = byte_ff;

endmodule

[rtl/wsdu_parser.sv]
// Header/length/key phase machine and payload unmask XOR.
// Depends on wsdu_pkg.
`timescale 1ns / 1ps

module wsdu_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   output wsdu_pkg::parse_result_type result
);
   import wsdu_pkg::*;

   phase_type   phase_ff,  phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff,    fin_in;
   logic [63:0] length_ff, length_in;
   logic [2:0]  count_ff,  count_in;
   logic [31:0] key_ff,    key_in;
   logic [63:0] remain_ff, remain_in;
   logic [1:0]  kidx_ff,   kidx_in;
   logic [6:0]  len7;
   logic [7:0]  key_byte;
   logic        emit;
   kind_type    emit_kind;
   logic [7:0]  emit_data;
   logic        emit_last;

   assign len7 = rx_byte[6:0];

   always_comb begin
      unique case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      length_in = length_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      remain_in = remain_ff;
      kidx_in   = kidx_ff;
      emit      = 1'b0;
      emit_kind = KIND_DATA;
      emit_data = 8'd0;
      emit_last = 1'b0;
      unique case (phase_ff)
         PH_HDR2: begin
            if (!rx_byte[7]) begin
               emit      = 1'b1;
               emit_kind = KIND_ERROR;
               emit_last = 1'b1;
               phase_in  = PH_HDR1;
            end else if (len7 < LEN7_EXT16) begin
               length_in = {57'd0, len7};
               count_in  = 3'd0;
               phase_in  = PH_KEY;
            end else begin
               length_in = 64'd0;
               count_in  = (len7 == LEN7_EXT64) ? EXT64_COUNT : EXT16_COUNT;
               phase_in  = PH_EXT;
            end
         end
         PH_EXT: begin
            length_in = {length_ff[55:0], rx_byte};
            if (count_ff == 3'd0) begin
               phase_in = PH_KEY;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], rx_byte};
            if (count_ff >= KEY_LAST) begin
               count_in = 3'd0;
               kidx_in  = 2'd0;
               if (length_ff == 64'd0) begin
                  emit      = 1'b1;
                  emit_kind = KIND_EMPTY;
                  emit_last = 1'b1;
                  phase_in  = PH_HDR1;
               end else begin
                  remain_in = length_ff;
                  phase_in  = PH_DATA;
               end
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_DATA: begin
            emit      = 1'b1;
            emit_kind = KIND_DATA;
            emit_data = rx_byte ^ key_byte;
            emit_last = (remain_ff == 64'd1);
            remain_in = remain_ff - 64'd1;
            kidx_in   = kidx_ff + 2'd1;
            if (remain_ff == 64'd1) begin
               phase_in = PH_HDR1;
            end
         end
         default: begin
            fin_in    = rx_byte[7];
            opcode_in = rx_byte[3:0];
            length_in = 64'd0;
            count_in  = 3'd0;
            kidx_in   = 2'd0;
            remain_in = 64'd0;
            phase_in  = PH_HDR2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR1;
         opcode_ff <= 4'd0;
         fin_ff    <= 1'b0;
         length_ff <= 64'd0;
         count_ff  <= 3'd0;
         key_ff    <= 32'd0;
         remain_ff <= 64'd0;
         kidx_ff   <= 2'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         remain_ff <= remain_in;
         kidx_ff   <= kidx_in;
      end
   end

   assign result.valid                  = step && emit;
   assign result.payload.kind           = emit_kind;
   assign result.payload.data_byte      = emit_data;
   assign result.payload.last           = emit_last;
   assign result.payload.frame_opcode   = opcode_ff;
   assign result.payload.frame_fin      = fin_ff;
   assign result.payload.payload_length = length_ff;

endmodule

[rtl/wsdu_out_stage.sv]
// Result register driving the response channel.
// Depends on wsdu_pkg and wsdu_rsp_if.
`timescale 1ns / 1ps

module wsdu_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  wsdu_pkg::parse_result_type result,
   output logic                       free,
   wsdu_rsp_if.source                 rsp_chan
);
   import wsdu_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;
   rsp_payload_type payload_in;

   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (free) begin
         valid_in = result.valid;
         if (result.valid) begin
            payload_in = result.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = payload_ff;

endmodule

[rtl/websocket_frame_deframer_unmask.sv]
// Channel    Dir  Payload                                         Transfer
// req_chan   in   rx_byte[7:0]                                    valid & ready
// rsp_chan   out  kind, data_byte, last, frame_opcode, frame_fin, valid & ready
//                 payload_length[63:0]
// One byte per cycle sustained while the response channel is not stalled.
// The input register feeds the phase machine, whose result loads the output register.
// A byte steps the parser only when the output register is free, whether or not
// it yields a result; a stalled response holds one byte in the input register.
// Synchronous reset returns the parser to awaiting a first header byte.
// Top level of the frame deframer/unmask block.
// Depends on wsdu_pkg, wsdu_ifs, wsdu_in_stage, wsdu_parser, wsdu_out_stage.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_unmask_defines.svh"

module websocket_frame_deframer_unmask (
   input  logic       clock,
   input  logic       reset,
   wsdu_req_if.sink   req_chan,
   wsdu_rsp_if.source rsp_chan
);
   import wsdu_pkg::*;

   in_stage_type     in_stage;
   parse_result_type parse_res;
   logic             out_free;
   logic             advance;
   logic             rsp_ctrl;
   logic             rsp_ctrl_ok;
   logic             in_stall;

   assign advance = in_stage.valid && out_free;

   wsdu_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .advance   (advance),
      .stage_out (in_stage)
   );

   wsdu_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_stage.rx_byte),
      .result  (parse_res)
   );

   wsdu_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (parse_res),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   assign rsp_ctrl    = rsp_chan.valid && rsp_chan.payload.kind != KIND_DATA;
   assign rsp_ctrl_ok = rsp_chan.payload.last && rsp_chan.payload.data_byte == 8'd0;
   assign in_stall    = in_stage.valid && !out_free;

   `WSDU_ASSERT_IMPLY(a_end_marks_last, rsp_ctrl, rsp_ctrl_ok, "non-data result not final")
   `WSDU_ASSERT_IMPLY(a_result_has_room, parse_res.valid, advance, "result without a free output")
   `WSDU_ASSERT_NEXT(a_in_holds, in_stall, in_stage.valid, "held byte dropped")
   `WSDU_ASSERT_NEXT(a_in_byte_holds, in_stall, $stable(in_stage.rx_byte), "held byte changed")

endmodule
